/* rtl/core/icfs_pkg.sv */
// Shared types and constants for the cosine force spreader.
// No dependencies; used by ib_cosine_force_spreader and its checker.
package icfs_pkg;

    localparam int KERNEL_WIDTH = 4;
    localparam int KIDX_W       = 2;
    localparam int N_AXES       = 3;
    localparam int FRAC_BITS    = 16;
    localparam int POS_W        = 26;
    localparam int POS_INT_W    = POS_W - FRAC_BITS;
    localparam int FORCE_W      = 32;
    localparam int GRID_W       = 12;
    localparam int DIM_W        = 11;
    localparam int COS_W        = 17;
    localparam int FAC_W        = 18;
    localparam int V_W          = 31;
    localparam int WXY_W        = 35;
    localparam int WEIGHT_W     = 28;
    localparam int PROD_W       = 61;
    localparam int CNT_W        = 6;

    localparam int IN_TDATA_W   = 176;
    localparam int FORCE_LO     = N_AXES * POS_W;
    localparam int OUT_TDATA_W  = 136;
    localparam int SPREAD_LO    = N_AXES * GRID_W;
    localparam int OUT_USED_W   = SPREAD_LO + N_AXES * FORCE_W;

    localparam int CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DIM_Z = 2'd2;
    localparam logic [DIM_W-1:0]     DIM_RESET      = 11'd1024;

    localparam logic [COS_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [31:0]      ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0]      COS_C5  = 32'd27060;
    localparam logic [31:0]      COS_C4  = 32'd987048;
    localparam logic [31:0]      COS_C3  = 32'd22401992;
    localparam logic [31:0]      COS_C2  = 32'd272375560;
    localparam logic [31:0]      COS_C1  = 32'd1324675879;
    localparam logic [30:0]      COS_RND = 31'd8192;

    localparam logic [2:0]       N_COS    = 3'd6;
    localparam logic [CNT_W-1:0] LAST_CNT = 6'd63;

    // one cosine evaluation in flight: axis and which argument (f or 1-f)
    typedef struct packed {
        logic [1:0] axis;
        logic       sel;
    } cos_tag_t;

endpackage

/* rtl/core/ib_cosine_force_spreader.sv */
// Immersed-boundary force spreading with the 4-point cosine kernel (top level).
// Depends on icfs_pkg.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  s_      | in  | s_tvalid / s_tready    | s_tdata: fiber node position + force
//  m_      | out | m_tvalid / m_tready    | m_tdata, m_tuser (oob), m_tlast
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (grid dims)
//
// Each node yields 64 results, which leave one per cycle on the m_ port while
// m_tready does not stall them. The cosine front end (one pipelined Horner
// unit, six arguments) overlaps the previous node's results.
// aresetn is synchronous; grid dims reset to 1024. A stall on m_tready
// freezes the whole result pipeline; nothing is lost or repeated.
module ib_cosine_force_spreader #(
    parameter int GRID_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pos_x, pos_y, pos_z, force_x, force_y, force_z, zero pad
    input  logic [icfs_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // grid_x, grid_y, grid_z, spread_x, spread_y, spread_z, zero pad
    output logic [icfs_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // out_of_bounds
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [icfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [icfs_pkg::DIM_W-1:0]           cfg_data
);

    localparam int INT_W = (GRID_BITS < icfs_pkg::POS_INT_W) ? GRID_BITS
                                                             : icfs_pkg::POS_INT_W;

    localparam int NA  = icfs_pkg::N_AXES;
    localparam int KW  = icfs_pkg::KERNEL_WIDTH;
    localparam int FW  = icfs_pkg::FAC_W;
    localparam int GW  = icfs_pkg::GRID_W;
    localparam int CW  = icfs_pkg::COS_W;
    localparam int FRW = icfs_pkg::FORCE_W;

    // ---------------- configuration
    logic [icfs_pkg::DIM_W-1:0] dim_reg [NA];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NA; a++) begin
                dim_reg[a] <= icfs_pkg::DIM_RESET;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                icfs_pkg::REG_GRID_DIM_X: dim_reg[0] <= cfg_data;
                icfs_pkg::REG_GRID_DIM_Y: dim_reg[1] <= cfg_data;
                icfs_pkg::REG_GRID_DIM_Z: dim_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- front end: node capture and argument issue
    logic                     fe_busy_reg;
    logic [2:0]               iss_cnt_reg;
    logic [2:0]               col_cnt_reg;
    logic [icfs_pkg::POS_W-1:0] node_pos_reg [NA];
    logic signed [FRW-1:0]    node_force_reg [NA];

    logic                     s_acc;
    logic                     iss_go;
    logic                     load;
    logic                     adv;
    logic [15:0]              iss_frac;
    logic [CW-1:0]            iss_u_next;
    icfs_pkg::cos_tag_t       iss_tag_next;

    assign s_tready = !fe_busy_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign iss_go   = fe_busy_reg && (iss_cnt_reg != icfs_pkg::N_COS);

    always_comb begin
        iss_tag_next.axis = iss_cnt_reg[2:1];
        iss_tag_next.sel  = iss_cnt_reg[0];
        case (iss_cnt_reg[2:1])
            2'd0:    iss_frac = node_pos_reg[0][15:0];
            2'd1:    iss_frac = node_pos_reg[1][15:0];
            2'd2:    iss_frac = node_pos_reg[2][15:0];
            default: iss_frac = '0;
        endcase
        if (iss_cnt_reg[0]) begin
            iss_u_next = icfs_pkg::ONE_Q16 - {1'b0, iss_frac};
        end else begin
            iss_u_next = {1'b0, iss_frac};
        end
    end

    // ---------------- cosine pipeline
    logic                     iss_vld_reg, c1_vld_reg, c2_vld_reg, c3_vld_reg;
    logic                     c4_vld_reg, c5_vld_reg, c6_vld_reg;
    icfs_pkg::cos_tag_t       iss_tag_reg, c1_tag_reg, c2_tag_reg, c3_tag_reg;
    icfs_pkg::cos_tag_t       c4_tag_reg, c5_tag_reg, c6_tag_reg;
    logic [CW-1:0]            iss_u_reg;
    logic [icfs_pkg::V_W-1:0] c1_v_reg, c2_v_reg, c3_v_reg, c4_v_reg, c5_v_reg;
    logic [19:0]              c2_t_reg;
    logic [24:0]              c3_t_reg;
    logic [28:0]              c4_t_reg;
    logic [30:0]              c5_t_reg;
    logic signed [31:0]       c6_s_reg;

    logic [33:0]              sq;
    logic [61:0]              pr2, pr3, pr4, pr5, pr6;
    logic [icfs_pkg::V_W-1:0] c1_v_next;
    logic [19:0]              c2_t_next;
    logic [24:0]              c3_t_next;
    logic [28:0]              c4_t_next;
    logic [30:0]              c5_t_next;
    logic signed [31:0]       c6_s_next;
    logic [30:0]              s_cl;
    logic [30:0]              s_rnd;
    logic [CW-1:0]            cos_res;

    always_comb begin
        sq        = 34'(iss_u_reg) * 34'(iss_u_reg);
        c1_v_next = sq[32:2];
        pr2       = 62'(icfs_pkg::COS_C5) * 62'(c1_v_reg);
        c2_t_next = 20'(icfs_pkg::COS_C4 - pr2[61:30]);
        pr3       = 62'(c2_t_reg) * 62'(c2_v_reg);
        c3_t_next = 25'(icfs_pkg::COS_C3 - pr3[61:30]);
        pr4       = 62'(c3_t_reg) * 62'(c3_v_reg);
        c4_t_next = 29'(icfs_pkg::COS_C2 - pr4[61:30]);
        pr5       = 62'(c4_t_reg) * 62'(c4_v_reg);
        c5_t_next = 31'(icfs_pkg::COS_C1 - pr5[61:30]);
        pr6       = 62'(c5_t_reg) * 62'(c5_v_reg);
        c6_s_next = $signed(icfs_pkg::ONE_Q30 - pr6[61:30]);
        if (c6_s_reg[31]) begin
            s_cl = '0;
        end else if (c6_s_reg > $signed(icfs_pkg::ONE_Q30)) begin
            s_cl = icfs_pkg::ONE_Q30[30:0];
        end else begin
            s_cl = c6_s_reg[30:0];
        end
        s_rnd   = s_cl + icfs_pkg::COS_RND;
        cos_res = s_rnd[30:14];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_vld_reg <= 1'b0;
            c1_vld_reg  <= 1'b0;
            c2_vld_reg  <= 1'b0;
            c3_vld_reg  <= 1'b0;
            c4_vld_reg  <= 1'b0;
            c5_vld_reg  <= 1'b0;
            c6_vld_reg  <= 1'b0;
        end else begin
            iss_vld_reg <= iss_go;
            c1_vld_reg  <= iss_vld_reg;
            c2_vld_reg  <= c1_vld_reg;
            c3_vld_reg  <= c2_vld_reg;
            c4_vld_reg  <= c3_vld_reg;
            c5_vld_reg  <= c4_vld_reg;
            c6_vld_reg  <= c5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        iss_u_reg   <= iss_u_next;
        iss_tag_reg <= iss_tag_next;
        c1_v_reg    <= c1_v_next;
        c1_tag_reg  <= iss_tag_reg;
        c2_t_reg    <= c2_t_next;
        c2_v_reg    <= c1_v_reg;
        c2_tag_reg  <= c1_tag_reg;
        c3_t_reg    <= c3_t_next;
        c3_v_reg    <= c2_v_reg;
        c3_tag_reg  <= c2_tag_reg;
        c4_t_reg    <= c4_t_next;
        c4_v_reg    <= c3_v_reg;
        c4_tag_reg  <= c3_tag_reg;
        c5_t_reg    <= c5_t_next;
        c5_v_reg    <= c4_v_reg;
        c5_tag_reg  <= c4_tag_reg;
        c6_s_reg    <= c6_s_next;
        c6_tag_reg  <= c5_tag_reg;
    end

    // ---------------- pending cosine results, front-end control
    logic [CW-1:0] pend_cf_reg [NA];
    logic [CW-1:0] pend_cg_reg [NA];

    always_ff @(posedge aclk) begin
        if (c6_vld_reg) begin
            for (int a = 0; a < NA; a++) begin
                if (c6_tag_reg.axis == 2'(a)) begin
                    if (c6_tag_reg.sel) begin
                        pend_cg_reg[a] <= cos_res;
                    end else begin
                        pend_cf_reg[a] <= cos_res;
                    end
                end
            end
        end
        if (s_acc) begin
            for (int a = 0; a < NA; a++) begin
                node_pos_reg[a]   <= s_tdata[a*icfs_pkg::POS_W +: icfs_pkg::POS_W];
                node_force_reg[a] <= $signed(s_tdata[icfs_pkg::FORCE_LO + a*FRW +: FRW]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fe_busy_reg <= 1'b0;
            iss_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else begin
            if (s_acc) begin
                fe_busy_reg <= 1'b1;
                iss_cnt_reg <= '0;
                col_cnt_reg <= '0;
            end else begin
                if (load) begin
                    fe_busy_reg <= 1'b0;
                end
                if (iss_go) begin
                    iss_cnt_reg <= iss_cnt_reg + 3'd1;
                end
                if (c6_vld_reg) begin
                    col_cnt_reg <= col_cnt_reg + 3'd1;
                end
            end
        end
    end

    // ---------------- active node and result walker
    logic                     act_vld_reg;
    logic [icfs_pkg::CNT_W-1:0] act_cnt_reg;
    logic [FW-1:0]            act_fac_reg [NA][KW];
    logic signed [GW-1:0]     act_base_reg [NA];
    logic signed [FRW-1:0]    act_force_reg [NA];

    logic [FW-1:0]            fac_next [NA][KW];
    logic signed [GW-1:0]     base_next [NA];

    assign adv  = !m_tvalid || m_tready;
    assign load = fe_busy_reg && (col_cnt_reg == icfs_pkg::N_COS) &&
                  (!act_vld_reg || (adv && act_cnt_reg == icfs_pkg::LAST_CNT));

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            if (node_pos_reg[a][15:0] == 16'd0) begin
                fac_next[a][0] = FW'(icfs_pkg::ONE_Q16) + FW'(pend_cg_reg[a]);
            end else begin
                fac_next[a][0] = FW'(icfs_pkg::ONE_Q16) - FW'(pend_cg_reg[a]);
            end
            fac_next[a][1] = FW'(icfs_pkg::ONE_Q16) + FW'(pend_cf_reg[a]);
            fac_next[a][2] = FW'(icfs_pkg::ONE_Q16) + FW'(pend_cg_reg[a]);
            fac_next[a][3] = FW'(icfs_pkg::ONE_Q16) - FW'(pend_cf_reg[a]);
            base_next[a]   = $signed(GW'(node_pos_reg[a][icfs_pkg::FRAC_BITS +: INT_W]))
                             - $signed(GW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_vld_reg <= 1'b0;
            act_cnt_reg <= '0;
        end else if (load) begin
            act_vld_reg <= 1'b1;
            act_cnt_reg <= '0;
        end else if (adv && act_vld_reg) begin
            if (act_cnt_reg == icfs_pkg::LAST_CNT) begin
                act_vld_reg <= 1'b0;
            end
            act_cnt_reg <= act_cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            act_fac_reg   <= fac_next;
            act_base_reg  <= base_next;
            act_force_reg <= node_force_reg;
        end
    end

    // ---------------- result pipeline P1..P4, output register
    logic [icfs_pkg::KIDX_W-1:0] kidx [NA];
    logic signed [GW-1:0]     p1_grid_next [NA];
    logic                     p1_oob_next;

    logic                     p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    logic signed [GW-1:0]     p1_grid_reg [NA];
    logic signed [GW-1:0]     p2_grid_reg [NA];
    logic signed [GW-1:0]     p3_grid_reg [NA];
    logic signed [GW-1:0]     p4_grid_reg [NA];
    logic [FW-1:0]            p1_fac_reg [NA];
    logic [icfs_pkg::WXY_W-1:0] p2_wxy_reg;
    logic [FW-1:0]            p2_wz_reg;
    logic [icfs_pkg::WEIGHT_W-1:0] p3_weight_reg;
    logic signed [icfs_pkg::PROD_W-1:0] p4_prod_reg [NA];
    logic signed [FRW-1:0]    p1_force_reg [NA];
    logic signed [FRW-1:0]    p2_force_reg [NA];
    logic signed [FRW-1:0]    p3_force_reg [NA];
    logic                     p1_oob_reg, p2_oob_reg, p3_oob_reg, p4_oob_reg;
    logic                     p1_last_reg, p2_last_reg, p3_last_reg, p4_last_reg;

    logic [35:0]              wxy_full;
    logic [52:0]              wxyz_rnd;
    logic signed [icfs_pkg::PROD_W-1:0] prod_next [NA];
    logic signed [icfs_pkg::PROD_W:0]   spread_sum [NA];

    logic                     m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [icfs_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [icfs_pkg::OUT_TDATA_W-1:0] m_tdata_next;

    always_comb begin
        kidx[0]     = act_cnt_reg[5:4];
        kidx[1]     = act_cnt_reg[3:2];
        kidx[2]     = act_cnt_reg[1:0];
        p1_oob_next = 1'b0;
        for (int a = 0; a < NA; a++) begin
            p1_grid_next[a] = act_base_reg[a] + $signed(GW'(kidx[a]));
            if (p1_grid_next[a][GW-1] ||
                (p1_grid_next[a][icfs_pkg::DIM_W-1:0] >= dim_reg[a])) begin
                p1_oob_next = 1'b1;
            end
        end
        wxy_full = 36'(p1_fac_reg[0]) * 36'(p1_fac_reg[1]);
        wxyz_rnd = 53'(p2_wxy_reg) * 53'(p2_wz_reg) + 53'(1 << 23);
        m_tdata_next = '0;
        for (int a = 0; a < NA; a++) begin
            prod_next[a]  = icfs_pkg::PROD_W'(p3_force_reg[a]) *
                            icfs_pkg::PROD_W'($signed({1'b0, p3_weight_reg}));
            spread_sum[a] = (icfs_pkg::PROD_W+1)'(p4_prod_reg[a]) +
                            (icfs_pkg::PROD_W+1)'(1 << 29);
            m_tdata_next[a*GW +: GW] = p4_grid_reg[a];
            if (!p4_oob_reg) begin
                m_tdata_next[icfs_pkg::SPREAD_LO + a*FRW +: FRW] =
                    spread_sum[a][icfs_pkg::PROD_W:icfs_pkg::PROD_W-FRW+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p3_vld_reg   <= 1'b0;
            p4_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg   <= act_vld_reg;
            p2_vld_reg   <= p1_vld_reg;
            p3_vld_reg   <= p2_vld_reg;
            p4_vld_reg   <= p3_vld_reg;
            m_tvalid_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < NA; a++) begin
                p1_grid_reg[a]  <= p1_grid_next[a];
                p1_fac_reg[a]   <= act_fac_reg[a][kidx[a]];
                p1_force_reg[a] <= act_force_reg[a];
                p2_grid_reg[a]  <= p1_grid_reg[a];
                p2_force_reg[a] <= p1_force_reg[a];
                p3_grid_reg[a]  <= p2_grid_reg[a];
                p3_force_reg[a] <= p2_force_reg[a];
                p4_grid_reg[a]  <= p3_grid_reg[a];
                p4_prod_reg[a]  <= prod_next[a];
            end
            p1_oob_reg    <= p1_oob_next;
            p1_last_reg   <= (act_cnt_reg == icfs_pkg::LAST_CNT);
            p2_wxy_reg    <= wxy_full[icfs_pkg::WXY_W-1:0];
            p2_wz_reg     <= p1_fac_reg[2];
            p2_oob_reg    <= p1_oob_reg;
            p2_last_reg   <= p1_last_reg;
            p3_weight_reg <= wxyz_rnd[51:24];
            p3_oob_reg    <= p2_oob_reg;
            p3_last_reg   <= p2_last_reg;
            p4_oob_reg    <= p3_oob_reg;
            p4_last_reg   <= p3_last_reg;
            m_tdata_reg   <= m_tdata_next;
            m_tuser_reg   <= p4_oob_reg;
            m_tlast_reg   <= p4_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/core/icfs_checker.sv */
// Port-level checks on the result channel of ib_cosine_force_spreader.
// Depends on icfs_pkg; bound to the top level at the end of this file.
module icfs_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [icfs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[icfs_pkg::OUT_USED_W-1:icfs_pkg::SPREAD_LO] == '0)
        else $error("out-of-bounds item carries non-zero force");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[icfs_pkg::OUT_TDATA_W-1:icfs_pkg::OUT_USED_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind ib_cosine_force_spreader icfs_checker u_icfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
